### rtl/psdp_pkg.sv
// Shared types and constants for the point-set distance/projection block.
// Used by psdp_ctrl, psdp_dp and point_set_distance_projection.
package psdp_pkg;

  localparam int CMD_W     = 3;
  localparam int PIDX_W    = 14;
  localparam int DIM_W     = 4;
  localparam int VAL_W     = 32;
  localparam int RES_W     = 48;
  localparam int ST_W      = 2;
  localparam int CNT_W     = 15;
  localparam int CFG_IDX_W = 2;

  localparam int POINTS_DEF     = 16384;
  localparam int DIMS_DEF       = 10;
  localparam int COORD_BITS_DEF = 32;

  localparam logic [CMD_W-1:0] CMD_STORE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOADA = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOADB = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIST  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PROJ  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_ZERO  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_B = 2'd1;

  localparam logic [RES_W-1:0] RES_MAXPOS = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] RES_MAXNEG = {1'b1, {(RES_W-1){1'b0}}};

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic inc_dim;
    logic diff_en;
    logic mula;
    logic acca;
    logic mulb;
    logic accb;
    logic sq_init;
    logic sq_step;
    logic dv_init;
    logic dv_step;
    logic load_out;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic range_bad;
    logic is_proj;
    logic last_dim;
    logic iter_last;
    logic root_zero;
    logic out_free;
  } dp_sts_t;

endpackage

### rtl/psdp_ctrl.sv
// Sequencer for the distance/projection block: accepts items, steps the
// datapath through the per-dimension MAC, square root and divide. Uses psdp_pkg.
module psdp_ctrl
  import psdp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_stall,
  input  dp_sts_t          sts,
  output dp_cmd_t          cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_DIFF  = 4'd3;
  localparam logic [3:0] S_MULA  = 4'd4;
  localparam logic [3:0] S_ACCA  = 4'd5;
  localparam logic [3:0] S_MULB  = 4'd6;
  localparam logic [3:0] S_ACCB  = 4'd7;
  localparam logic [3:0] S_SQI   = 4'd8;
  localparam logic [3:0] S_SQ    = 4'd9;
  localparam logic [3:0] S_SQD   = 4'd10;
  localparam logic [3:0] S_DV    = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       fire, is_comp;

  assign in_stall = (state_r != S_IDLE);
  assign fire     = in_valid && !in_stall;
  assign is_comp  = (in_command == CMD_DIST) || (in_command == CMD_PROJ);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.accept = fire;
    unique case (state_r)
      S_IDLE: begin
        if (fire && is_comp) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = sts.range_bad ? S_OUT : S_RD;
      end
      S_RD:   state_nxt = S_DIFF;
      S_DIFF: begin
        cmd.diff_en = 1'b1;
        state_nxt   = S_MULA;
      end
      S_MULA: begin
        cmd.mula  = 1'b1;
        state_nxt = S_ACCA;
      end
      S_ACCA: begin
        cmd.acca = 1'b1;
        if (sts.is_proj) begin
          state_nxt = S_MULB;
        end else if (sts.last_dim) begin
          state_nxt = S_SQI;
        end else begin
          cmd.inc_dim = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_MULB: begin
        cmd.mulb  = 1'b1;
        state_nxt = S_ACCB;
      end
      S_ACCB: begin
        cmd.accb = 1'b1;
        if (sts.last_dim) begin
          state_nxt = S_SQI;
        end else begin
          cmd.inc_dim = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_SQI: begin
        cmd.sq_init = 1'b1;
        state_nxt   = S_SQ;
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        if (sts.iter_last) state_nxt = S_SQD;
      end
      S_SQD: begin
        if (sts.is_proj && !sts.root_zero) begin
          cmd.dv_init = 1'b1;
          state_nxt   = S_DV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DV: begin
        cmd.dv_step = 1'b1;
        if (sts.iter_last) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

### rtl/psdp_dp.sv
// Datapath: point store and query memories, MAC, bit-serial square root,
// restoring divider and the result register. Uses psdp_pkg.
module psdp_dp
  import psdp_pkg::*;
#(
  parameter int POINTS     = POINTS_DEF,
  parameter int DIMS       = DIMS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_sts_t                 sts,
  input  logic [CMD_W-1:0]        in_command,
  input  logic                    in_set_select,
  input  logic [PIDX_W-1:0]       in_point_index,
  input  logic [DIM_W-1:0]        in_dim_index,
  input  logic signed [VAL_W-1:0] in_coord_value,
  input  logic [CNT_W-1:0]        count_a,
  input  logic [CNT_W-1:0]        count_b,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [RES_W-1:0] out_result_value,
  output logic [ST_W-1:0]         out_status
);

  localparam int CW    = COORD_BITS;
  localparam int DEPTH = 2 * POINTS * DIMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int MW    = CW + 1;
  localparam int PW    = 2 * MW;
  localparam int ACCW  = PW + $clog2(DIMS + 1) + 1;
  localparam int SQW   = (ACCW + 1) / 2;
  localparam int ITW   = $clog2(ACCW + 1);
  localparam int CMPW  = ACCW + RES_W;

  logic [CW-1:0] mem_q [0:DEPTH-1];
  logic [CW-1:0] qa_q  [0:DIMS-1];
  logic [CW-1:0] qb_q  [0:DIMS-1];

  logic [CW-1:0] pt_rd_r, qa_rd_r, qb_rd_r;
  logic [AW-1:0] base_r, wr_addr, rd_addr, base_nxt;
  logic [DW-1:0] dim_r, wr_dim;
  logic          range_bad_r, is_proj_r, neg_r;
  logic [MW-1:0] mag1_r, mag2_r, mul_b;
  logic [PW-1:0] prod_r;
  logic [ACCW-1:0]        dir_r;
  logic signed [ACCW-1:0] dot_r;
  logic [2*SQW-1:0] sq_src_r;
  logic [SQW+1:0]   rem_r;
  logic [SQW-1:0]   root_r;
  logic [SQW+3:0]   rem_sh, trial;
  logic [ACCW-1:0]  dv_r;
  logic [SQW-1:0]   dr_r;
  logic [SQW:0]     dr_sh;
  logic             dr_ge;
  logic [ITW-1:0]   iter_r;
  logic             out_valid_r;
  logic signed [RES_W-1:0] out_res_r;
  logic [ST_W-1:0]  out_st_r;
  logic signed [MW-1:0] ca, cb, cp, d1, d2;
  logic [CNT_W-1:0] sel_cnt;
  logic             bad_now, wr_ok, dim_ok;
  logic [CMPW-1:0]  q_ext, root_ext;
  logic [RES_W-1:0] q_sat, res_val;
  logic [ST_W-1:0]  res_st;

  assign wr_dim  = DW'(in_dim_index);
  assign dim_ok  = {28'd0, in_dim_index} < 32'(DIMS);
  assign wr_ok   = {18'd0, in_point_index} < 32'(POINTS);
  assign base_nxt = AW'((AW'(in_set_select) * AW'(POINTS) + AW'(in_point_index))
                        * AW'(DIMS));
  assign wr_addr = base_nxt + AW'(in_dim_index);
  assign rd_addr = base_r + AW'(dim_r);

  // memories: one write port from the input, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.accept && dim_ok && wr_ok && in_command == CMD_STORE) begin
      mem_q[wr_addr] <= in_coord_value[CW-1:0];
    end
    pt_rd_r <= mem_q[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && dim_ok && in_command == CMD_LOADA) qa_q[wr_dim] <= in_coord_value[CW-1:0];
    if (cmd.accept && dim_ok && in_command == CMD_LOADB) qb_q[wr_dim] <= in_coord_value[CW-1:0];
    qa_rd_r <= qa_q[dim_r];
    qb_rd_r <= qb_q[dim_r];
  end

  assign sel_cnt = in_set_select ? count_b : count_a;
  assign bad_now = ({1'b0, in_point_index} >= sel_cnt) || !wr_ok;

  assign ca = MW'($signed(qa_rd_r));
  assign cb = MW'($signed(qb_rd_r));
  assign cp = MW'($signed(pt_rd_r));
  assign d1 = is_proj_r ? (cb - ca) : (ca - cp);
  assign d2 = cp - ca;
  assign mul_b = cmd.mulb ? mag2_r : mag1_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      base_r      <= base_nxt;
      range_bad_r <= bad_now;
      is_proj_r   <= (in_command == CMD_PROJ);
      dir_r       <= '0;
      dot_r       <= '0;
    end
    if (cmd.diff_en) begin
      mag1_r <= d1[MW-1] ? MW'(-d1) : MW'(d1);
      mag2_r <= d2[MW-1] ? MW'(-d2) : MW'(d2);
      neg_r  <= d1[MW-1] ^ d2[MW-1];
    end
    if (cmd.mula || cmd.mulb) prod_r <= mag1_r * mul_b;
    if (cmd.acca) dir_r <= dir_r + ACCW'(prod_r);
    if (cmd.accb) begin
      dot_r <= neg_r ? dot_r - $signed(ACCW'(prod_r)) : dot_r + $signed(ACCW'(prod_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= '0;
    end else if (cmd.accept) begin
      dim_r <= '0;
    end else if (cmd.inc_dim) begin
      dim_r <= dim_r + 1'b1;
    end
  end

  // integer square root, two radicand bits per step
  assign rem_sh = {rem_r, sq_src_r[2*SQW-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};

  // restoring divide, one quotient bit per step
  assign dr_sh = {dr_r, dv_r[ACCW-1]};
  assign dr_ge = dr_sh >= {1'b0, root_r};

  always_ff @(posedge clk) begin
    if (cmd.sq_init) begin
      sq_src_r <= (2*SQW)'(dir_r);
      rem_r    <= '0;
      root_r   <= '0;
    end else if (cmd.sq_step) begin
      sq_src_r <= {sq_src_r[2*SQW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= (SQW+2)'(rem_sh - trial);
        root_r <= {root_r[SQW-2:0], 1'b1};
      end else begin
        rem_r  <= (SQW+2)'(rem_sh);
        root_r <= {root_r[SQW-2:0], 1'b0};
      end
    end
    if (cmd.dv_init) begin
      dv_r <= dot_r[ACCW-1] ? ACCW'(-dot_r) : ACCW'(dot_r);
      dr_r <= '0;
    end else if (cmd.dv_step) begin
      dr_r <= dr_ge ? SQW'(dr_sh - {1'b0, root_r}) : SQW'(dr_sh);
      dv_r <= {dv_r[ACCW-2:0], dr_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= '0;
    end else if (cmd.sq_init) begin
      iter_r <= ITW'(SQW - 1);
    end else if (cmd.dv_init) begin
      iter_r <= ITW'(ACCW - 1);
    end else if (cmd.sq_step || cmd.dv_step) begin
      iter_r <= iter_r - 1'b1;
    end
  end

  // final value with saturation to the 48-bit result range
  assign q_ext    = CMPW'(dv_r);
  assign root_ext = CMPW'(root_r);

  always_comb begin
    q_sat   = '0;
    res_val = '0;
    res_st  = ST_OK;
    if (range_bad_r) begin
      res_st = ST_RANGE;
    end else if (!is_proj_r) begin
      res_val = (root_ext > CMPW'(RES_MAXPOS)) ? RES_MAXPOS : RES_W'(root_ext);
    end else if (root_r == '0) begin
      res_st = ST_ZERO;
    end else if (dot_r[ACCW-1]) begin
      q_sat   = (q_ext > CMPW'(RES_MAXNEG)) ? RES_MAXNEG : RES_W'(q_ext);
      res_val = RES_W'(-q_sat);
    end else begin
      res_val = (q_ext > CMPW'(RES_MAXPOS)) ? RES_MAXPOS : RES_W'(q_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_res_r <= $signed(res_val);
      out_st_r  <= res_st;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_status       = out_st_r;

  assign sts.range_bad = range_bad_r;
  assign sts.is_proj   = is_proj_r;
  assign sts.last_dim  = (dim_r == DW'(DIMS - 1));
  assign sts.iter_last = (iter_r == '0);
  assign sts.root_zero = (root_r == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

### rtl/point_set_distance_projection.sv
// Top level: configuration registers, sequencer and datapath.
// Depends on psdp_pkg, psdp_ctrl and psdp_dp.
//
//  channel | handshake           | payload
//  in      | in_valid / in_stall | command, set_select, point_index, dim_index, coord_value
//  out     | out_valid/out_stall | result_value, status
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data (0 count_set_a, 1 count_set_b)
//
// Store and load items never close the input. A distance item runs the
// per-dimension MAC loop and the one-bit-per-cycle root; a projection runs a
// longer MAC loop, the root and, unless the root is zero, the divider (SQW =
// root bits, ACCW = accumulator bits; 36 and 71 by default). An out-of-range
// index goes from the check state straight to output. Reset is synchronous
// and needs no clearing pass. A waiting result does not block the next item;
// a new result waits in its last state while out_stall holds the previous one.
module point_set_distance_projection
  import psdp_pkg::*;
#(
  parameter int POINTS     = POINTS_DEF,
  parameter int DIMS       = DIMS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CMD_W-1:0]        in_command,
  input  logic                    in_set_select,
  input  logic [PIDX_W-1:0]       in_point_index,
  input  logic [DIM_W-1:0]        in_dim_index,
  input  logic signed [VAL_W-1:0] in_coord_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [RES_W-1:0] out_result_value,
  output logic [ST_W-1:0]         out_status,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CNT_W-1:0]        cfg_data
);

  logic [CNT_W-1:0] count_a_r, count_b_r;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r <= '0;
      count_b_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_COUNT_A) count_a_r <= cfg_data;
      if (cfg_index == REG_COUNT_B) count_b_r <= cfg_data;
    end
  end

  psdp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  psdp_dp #(
    .POINTS     (POINTS),
    .DIMS       (DIMS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_command       (in_command),
    .in_set_select    (in_set_select),
    .in_point_index   (in_point_index),
    .in_dim_index     (in_dim_index),
    .in_coord_value   (in_coord_value),
    .count_a          (count_a_r),
    .count_b          (count_b_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_status       (out_status)
  );

`ifndef NO_ASSERTIONS
  // a compute item keeps the input closed on the next cycle
  a_comp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_command == CMD_DIST || in_command == CMD_PROJ))
      |=> in_stall)
    else $error("compute item did not close the input");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3))
    else $error("undefined status code");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_RANGE || out_status == ST_ZERO))
      |-> (out_result_value == '0))
    else $error("flagged result carries a value");

  // a result is produced only from the busy sequence
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> in_stall)
    else $error("result loaded while idle");
`endif

endmodule
